[hw/rtl/rau_pkg.sv]
// Rational arithmetic unit: shared package.
// Operation codes, widths and the queue entry type. No dependencies.
package rau_pkg;
   localparam int OperandWidthDefault = 32;
   localparam int FieldWidth = 32;
   localparam int ResNumWidth = 64;
   localparam int ResDenWidth = 63;
   localparam int QueueDepthDefault = 2;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4,
      OP_RED = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0] op;
      logic       err;
      logic       zero_a;
      logic signed [FieldWidth-1:0] an;
      logic signed [FieldWidth-1:0] ad;
      logic signed [FieldWidth-1:0] bn;
      logic signed [FieldWidth-1:0] bd;
   } entry_type;
endpackage

[hw/rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: top level.
// Joins rau_front, rau_queue and rau_back. Uses rau_pkg.
//
// One request gives one response. Add, subtract, multiply, divide and compare
// go through the back end's shared 33x33 multiplier (three products, one a
// cycle). Reduce of a nonzero numerator runs a binary GCD then two 32-bit
// restoring divisions. The queue holds two requests so the front keeps
// accepting while the back end works.
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_op,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [63:0] rsp_res_num,
   output logic [62:0] rsp_res_den,
   output logic rsp_is_less,
   output logic rsp_is_equal,
   output logic rsp_status
);
   logic fq_valid, fq_full, qb_valid, qb_take;
   rau_pkg::entry_type fq_entry, qb_entry;

   rau_front #(.OperandWidth(OPERAND_WIDTH)) u_front (
      .req_valid, .req_stall, .req_op, .req_a_num,
      .req_a_den, .req_b_num, .req_b_den,
      .q_valid(fq_valid), .q_full(fq_full), .q_entry(fq_entry)
   );

   rau_queue u_queue (
      .clock, .reset, .wr_valid(fq_valid), .full(fq_full), .wr_data(fq_entry),
      .rd_valid(qb_valid), .rd_take(qb_take), .rd_data(qb_entry)
   );

   rau_back u_back (
      .clock, .reset, .q_valid(qb_valid), .q_take(qb_take), .q_entry(qb_entry),
      .rsp_valid, .rsp_stall, .rsp_res_num, .rsp_res_den, .rsp_is_less,
      .rsp_is_equal, .rsp_status
   );
endmodule

[hw/rtl/rau_front.sv]
// Rational arithmetic unit: front end.
// Accepts requests, sign-extends operands and flags error cases. Uses rau_pkg.
module rau_front #(
   parameter int OperandWidth = rau_pkg::OperandWidthDefault
) (
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_op,
   input  logic signed [rau_pkg::FieldWidth-1:0] req_a_num,
   input  logic signed [rau_pkg::FieldWidth-1:0] req_a_den,
   input  logic signed [rau_pkg::FieldWidth-1:0] req_b_num,
   input  logic signed [rau_pkg::FieldWidth-1:0] req_b_den,
   output logic q_valid,
   input  logic q_full,
   output rau_pkg::entry_type q_entry
);
   localparam int FW = rau_pkg::FieldWidth;

   function automatic logic signed [FW-1:0] sx(input logic [FW-1:0] v);
      logic [OperandWidth-1:0] t;
      t = v[OperandWidth-1:0];
      return FW'(signed'(t));
   endfunction

   logic signed [FW-1:0] an, ad, bn, bd;
   logic err;

   assign an = sx(req_a_num);
   assign ad = sx(req_a_den);
   assign bn = sx(req_b_num);
   assign bd = sx(req_b_den);

   always_comb begin
      unique case (req_op) inside
         rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL, rau_pkg::OP_CMP:
            err = (ad == '0) || (bd == '0);
         rau_pkg::OP_DIV: err = (ad == '0) || (bd == '0) || (bn == '0);
         rau_pkg::OP_RED: err = (ad == '0);
         default: err = 1'b1;
      endcase
   end

   assign req_stall = q_full;
   assign q_valid = req_valid;
   assign q_entry = '{op: req_op, err: err, zero_a: (an == '0),
                      an: an, ad: ad, bn: bn, bd: bd};
endmodule

[hw/rtl/rau_queue.sv]
// Rational arithmetic unit: request queue between front and back end.
// Small register FIFO of entry_type. Uses rau_pkg.
module rau_queue #(
   parameter int Depth = rau_pkg::QueueDepthDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic wr_valid,
   output logic full,
   input  rau_pkg::entry_type wr_data,
   output logic rd_valid,
   input  logic rd_take,
   output rau_pkg::entry_type rd_data
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   rau_pkg::entry_type mem_ff [Depth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic wr, rd;

   assign full = (cnt_ff == (AW+1)'(Depth));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && !full;
   assign rd = rd_take && rd_valid;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
      return (p == AW'(Depth-1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= nxt(wp_ff);
         if (rd) rp_ff <= nxt(rp_ff);
         if (wr && !rd) cnt_ff <= cnt_ff + 1'b1;
         else if (rd && !wr) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule

[hw/rtl/rau_back.sv]
// Rational arithmetic unit: back end.
// Shared 33x33 multiplier, binary GCD and restoring divider; output register.
// Uses rau_pkg.
module rau_back (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_take,
   input  rau_pkg::entry_type q_entry,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [rau_pkg::ResNumWidth-1:0] rsp_res_num,
   output logic [rau_pkg::ResDenWidth-1:0] rsp_res_den,
   output logic rsp_is_less,
   output logic rsp_is_equal,
   output logic rsp_status
);
   localparam int FW = rau_pkg::FieldWidth;
   localparam int NW = rau_pkg::ResNumWidth;
   localparam int DW = rau_pkg::ResDenWidth;
   localparam int MW = FW + 1;
   localparam int CW = $clog2(FW + 1);
   localparam logic signed [NW-1:0] SatMax = {1'b0, {(NW-1){1'b1}}};

   typedef enum logic [3:0] {
      S_IDLE, S_M1, S_M2, S_M3, S_FIN, S_GCD, S_DN, S_DD, S_OUT
   } state_type;

   state_type state_ff;
   logic [2:0] op_ff;
   logic signed [MW-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [NW-1:0] p0_ff, p1_ff, p2_ff;
   logic [FW-1:0] gx_ff, gy_ff, nm_ff, dm_ff;
   logic [CW-1:0] sh_ff;
   logic neg_ff;
   logic [FW-1:0] quo_ff, rem_ff;
   logic [CW-1:0] cnt_ff;
   logic [FW-1:0] dvd_ff;
   logic signed [NW-1:0] res_num_ff;
   logic [DW-1:0] res_den_ff;
   logic res_less_ff, res_eq_ff, res_stat_ff;
   logic signed [NW-1:0] onum_ff;
   logic [DW-1:0] oden_ff;
   logic oless_ff, oeq_ff, ostat_ff, ovalid_ff;

   logic signed [MW-1:0] ma, mb;
   logic signed [NW-1:0] prod;
   assign prod = NW'(ma * mb);

   always_comb begin
      ma = an_ff;
      mb = bd_ff;
      case (state_ff)
         S_M2: begin ma = bn_ff; mb = ad_ff; end
         S_M3: begin
            ma = ad_ff;
            mb = (op_ff == rau_pkg::OP_MUL) ? bd_ff :
                 (op_ff == rau_pkg::OP_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            ma = (op_ff == rau_pkg::OP_MUL) ? an_ff : an_ff;
            mb = (op_ff == rau_pkg::OP_MUL) ? bn_ff : bd_ff;
         end
      endcase
   end

   logic signed [NW:0] wsum;
   logic signed [NW-1:0] satsum;
   always_comb begin
      if (op_ff == rau_pkg::OP_SUB) wsum = (NW+1)'(p0_ff) - (NW+1)'(p1_ff);
      else wsum = (NW+1)'(p0_ff) + (NW+1)'(p1_ff);
      if (wsum > (NW+1)'(SatMax)) satsum = SatMax;
      else if (wsum < -(NW+1)'(SatMax)) satsum = -SatMax;
      else satsum = wsum[NW-1:0];
   end

   logic [FW:0] rtry;
   assign rtry = {rem_ff, dvd_ff[FW-1]} - {1'b0, gx_ff};

   assign q_take = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = ovalid_ff;
   assign rsp_res_num = onum_ff;
   assign rsp_res_den = oden_ff;
   assign rsp_is_less = oless_ff;
   assign rsp_is_equal = oeq_ff;
   assign rsp_status = ostat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               op_ff <= q_entry.op;
               an_ff <= (q_entry.ad < 0) ? -MW'(q_entry.an) : MW'(q_entry.an);
               ad_ff <= (q_entry.ad < 0) ? -MW'(q_entry.ad) : MW'(q_entry.ad);
               bn_ff <= (q_entry.bd < 0) ? -MW'(q_entry.bn) : MW'(q_entry.bn);
               bd_ff <= (q_entry.bd < 0) ? -MW'(q_entry.bd) : MW'(q_entry.bd);
               neg_ff <= (q_entry.an < 0) != (q_entry.ad < 0);
               nm_ff <= (q_entry.an < 0) ? FW'(-q_entry.an) : FW'(q_entry.an);
               dm_ff <= (q_entry.ad < 0) ? FW'(-q_entry.ad) : FW'(q_entry.ad);
               gx_ff <= (q_entry.an < 0) ? FW'(-q_entry.an) : FW'(q_entry.an);
               gy_ff <= (q_entry.ad < 0) ? FW'(-q_entry.ad) : FW'(q_entry.ad);
               sh_ff <= '0;
               res_num_ff <= '0;
               res_den_ff <= '0;
               res_less_ff <= 1'b0;
               res_eq_ff <= 1'b0;
               res_stat_ff <= 1'b0;
               if (q_entry.err) begin
                  res_stat_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else if (q_entry.op == rau_pkg::OP_RED) begin
                  if (q_entry.zero_a) begin
                     res_den_ff <= 63'd1;
                     state_ff <= S_OUT;
                  end else state_ff <= S_GCD;
               end else state_ff <= S_M1;
            end
            S_M1: begin p0_ff <= prod; state_ff <= S_M2; end
            S_M2: begin p1_ff <= prod; state_ff <= S_M3; end
            S_M3: begin p2_ff <= prod; state_ff <= S_FIN; end
            S_FIN: begin
               case (op_ff) inside
                  rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                     res_num_ff <= satsum;
                     res_den_ff <= p2_ff[DW-1:0];
                  end
                  rau_pkg::OP_MUL: begin
                     res_num_ff <= p0_ff;
                     res_den_ff <= p2_ff[DW-1:0];
                  end
                  rau_pkg::OP_DIV: begin
                     res_num_ff <= (p2_ff < 0) ? -p0_ff : p0_ff;
                     res_den_ff <= DW'((p2_ff < 0) ? -p2_ff : p2_ff);
                  end
                  default: begin
                     res_less_ff <= p0_ff < p1_ff;
                     res_eq_ff <= p0_ff == p1_ff;
                  end
               endcase
               state_ff <= S_OUT;
            end
            S_GCD: begin
               // binary GCD: one step (shift, or subtract and shift) per cycle
               if (gy_ff == '0) begin
                  gx_ff <= gx_ff << sh_ff;
                  dvd_ff <= nm_ff;
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= S_DN;
               end else if (!gx_ff[0] && !gy_ff[0]) begin
                  gx_ff <= gx_ff >> 1;
                  gy_ff <= gy_ff >> 1;
                  sh_ff <= sh_ff + 1'b1;
               end else if (!gx_ff[0]) gx_ff <= gx_ff >> 1;
               else if (!gy_ff[0]) gy_ff <= gy_ff >> 1;
               else if (gx_ff >= gy_ff) begin
                  gx_ff <= gy_ff;
                  gy_ff <= (gx_ff - gy_ff) >> 1;
               end else gy_ff <= (gy_ff - gx_ff) >> 1;
            end
            S_DN, S_DD: begin
               if (!rtry[FW]) begin
                  rem_ff <= rtry[FW-1:0];
                  quo_ff <= {quo_ff[FW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[FW-2:0], dvd_ff[FW-1]};
                  quo_ff <= {quo_ff[FW-2:0], 1'b0};
               end
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(FW-1)) begin
                  cnt_ff <= '0;
                  rem_ff <= '0;
                  if (state_ff == S_DN) begin
                     nm_ff <= {quo_ff[FW-2:0], !rtry[FW]};
                     dvd_ff <= dm_ff;
                     state_ff <= S_DD;
                  end else begin
                     res_num_ff <= neg_ff ? -NW'(nm_ff) : NW'(nm_ff);
                     res_den_ff <= DW'({quo_ff[FW-2:0], !rtry[FW]});
                     state_ff <= S_OUT;
                  end
               end
            end
            S_OUT: if (!ovalid_ff || !rsp_stall) begin
               onum_ff <= res_num_ff;
               oden_ff <= res_den_ff;
               oless_ff <= res_less_ff;
               oeq_ff <= res_eq_ff;
               ostat_ff <= res_stat_ff;
               ovalid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (ovalid_ff && !rsp_stall && state_ff != S_OUT) ovalid_ff <= 1'b0;
      end
   end
endmodule

[tb/tb_top.sv]
// Self-checking testbench for rational_arithmetic_unit: directed and random requests
// against an in-bench rational predictor. A scoreboard class holds the expected responses.
// Depends on rau_pkg and the rational_arithmetic_unit RTL only.
`timescale 1ns / 1ps

module tb_top;
   localparam logic [2:0] OpSpare6 = 3'd6;
   localparam logic [2:0] OpSpare7 = 3'd7;
   localparam int NumRequests = 600;
   localparam int IdleLimit = 3000;
   localparam int LongHold = 400;

   typedef struct {
      logic signed [63:0] num;
      logic [62:0]        den;
      logic               less;
      logic               equal;
      logic               status;
   } fraction_result;

   class fraction_scoreboard;
      fraction_result pending_q[$];
      int errors;
      int checked;
      int op_seen[8];

      function fraction_result compute(logic [2:0] op, logic signed [31:0] an32,
                                       logic signed [31:0] ad32,
                                       logic signed [31:0] bn32,
                                       logic signed [31:0] bd32);
         fraction_result r;
         longint an, ad, bn, bd, l, rr, num, den;
         longint unsigned n, d, x, y, t;
         logic signed [64:0] p, q, s;
         logic signed [64:0] lim;
         lim = 65'sd9223372036854775807;
         r = '{num: 0, den: 0, less: 0, equal: 0, status: 1};
         an = an32;
         ad = ad32;
         bn = bn32;
         bd = bd32;
         if (op == rau_pkg::OP_RED) begin
            if (ad == 0) return r;
            r.status = 0;
            if (an == 0) begin
               r.den = 63'd1;
               return r;
            end
            n = an < 0 ? -an : an;
            d = ad < 0 ? -ad : ad;
            x = n;
            y = d;
            while (y != 0) begin
               t = x % y;
               x = y;
               y = t;
            end
            n = n / x;
            d = d / x;
            r.num = ((an < 0) != (ad < 0)) ? -longint'(n) : longint'(n);
            r.den = d[62:0];
            return r;
         end
         if (op > rau_pkg::OP_RED || ad == 0 || bd == 0) return r;
         if (ad < 0) begin
            an = -an;
            ad = -ad;
         end
         if (bd < 0) begin
            bn = -bn;
            bd = -bd;
         end
         r.status = 0;
         case (op) inside
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
               p = an * bd;
               q = bn * ad;
               s = (op == rau_pkg::OP_ADD) ? p + q : p - q;
               if (s > lim) s = lim;
               if (s < -lim) s = -lim;
               r.num = s[63:0];
               r.den = 63'(ad * bd);
            end
            rau_pkg::OP_MUL: begin
               r.num = an * bn;
               r.den = 63'(ad * bd);
            end
            rau_pkg::OP_DIV: begin
               if (bn == 0) begin
                  r.status = 1;
               end else begin
                  num = an * bd;
                  den = ad * bn;
                  if (den < 0) begin
                     num = -num;
                     den = -den;
                  end
                  r.num = num;
                  r.den = den[62:0];
               end
            end
            default: begin
               l = an * bd;
               rr = bn * ad;
               r.less = l < rr;
               r.equal = l == rr;
            end
         endcase
         return r;
      endfunction

      function void note(logic [2:0] op, logic signed [31:0] an, logic signed [31:0] ad,
                         logic signed [31:0] bn, logic signed [31:0] bd);
         pending_q.push_back(compute(op, an, ad, bn, bd));
         op_seen[op]++;
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch at %0t on response %0d: %s got %h want %h",
                  $time, checked, what, got, want);
         errors++;
      endtask

      task check(fraction_result got);
         fraction_result want;
         if (pending_q.size() == 0) begin
            report("unexpected response", 64'(got.num), 64'd0);
            return;
         end
         want = pending_q.pop_front();
         if (got.num !== want.num) report("res_num", 64'(got.num), 64'(want.num));
         if (got.den !== want.den) report("res_den", 64'(got.den), 64'(want.den));
         if (got.less !== want.less) report("is_less", 64'(got.less), 64'(want.less));
         if (got.equal !== want.equal)
            report("is_equal", 64'(got.equal), 64'(want.equal));
         if (got.status !== want.status)
            report("status", 64'(got.status), 64'(want.status));
         checked++;
      endtask
   endclass

   logic clock = 0;
   logic reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic [2:0] req_op;
   logic signed [31:0] req_a_num, req_a_den, req_b_num, req_b_den;
   logic signed [63:0] rsp_res_num;
   logic [62:0] rsp_res_den;
   logic rsp_is_less, rsp_is_equal, rsp_status;

   fraction_scoreboard sb = new();
   int accepted;
   int idle_cycles;
   bit quiet;
   bit long_done;

   always #2 clock = ~clock;

   rational_arithmetic_unit DUT (.*);

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note(req_op, req_a_num, req_a_den, req_b_num, req_b_den);
         accepted++;
      end
      if (!reset && rsp_valid && !rsp_stall)
         sb.check('{num: rsp_res_num, den: rsp_res_den, less: rsp_is_less,
                    equal: rsp_is_equal, status: rsp_status});
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("timeout at %0t", $time);
         $display("rational_arithmetic_unit regression: fail");
         $finish;
      end
   end

   // response side: random stall bursts, one long hold-off to fill the block
   initial begin
      rsp_stall <= 0;
      @(negedge reset);
      forever begin
         if (!long_done && accepted >= 120) begin
            rsp_stall <= 1;
            repeat (LongHold) @(posedge clock);
            long_done = 1;
         end else if (quiet || $urandom_range(0, 2) == 0) begin
            rsp_stall <= 0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_stall <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
   end

   function logic [31:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 0;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return 32'(int'($urandom_range(0, 40)) - 20);
         4: return 32'(int'($urandom_range(0, 2000)) - 1000);
         5: return 1;
         default: return $urandom;
      endcase
   endfunction

   task send(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
             logic [31:0] bn, logic [31:0] bd);
      req_op <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task send_random();
      logic [2:0] op;
      logic [31:0] v;
      op = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      v = pick_value();
      if (op == rau_pkg::OP_RED && $urandom_range(0, 3) == 0)
         send(op, v * 32'($urandom_range(1, 50)), v * 32'($urandom_range(1, 50)), 0, 1);
      else
         send(op, pick_value(), pick_value(), pick_value(), pick_value());
   endtask

   initial begin
      reset <= 1;
      req_valid <= 0;
      req_op <= rau_pkg::OP_ADD;
      req_a_num <= 0;
      req_a_den <= 1;
      req_b_num <= 0;
      req_b_den <= 1;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(rau_pkg::OP_ADD, 32'h8000_0000, 1, 32'h8000_0000, 32'h8000_0000);
      send(rau_pkg::OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1);
      send(rau_pkg::OP_SUB, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send(rau_pkg::OP_ADD, 1, -3, 2, 5);
      send(rau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send(rau_pkg::OP_MUL, -7, 3, 0, -4);
      send(rau_pkg::OP_DIV, 3, 4, -5, 6);
      send(rau_pkg::OP_DIV, 3, 4, 0, 6);
      send(rau_pkg::OP_DIV, 32'h8000_0000, -1, 32'h8000_0000, 32'h7fff_ffff);
      send(rau_pkg::OP_CMP, 1, 2, 2, 4);
      send(rau_pkg::OP_CMP, -1, 2, 1, -3);
      send(rau_pkg::OP_CMP, 5, -1, 1, 1);
      send(rau_pkg::OP_ADD, 1, 0, 1, 1);
      send(rau_pkg::OP_CMP, 1, 1, 1, 0);
      send(rau_pkg::OP_RED, 0, -9, 1, 0);
      send(rau_pkg::OP_RED, 5, 0, 1, 1);
      send(rau_pkg::OP_RED, -6, -6, 0, 0);
      send(rau_pkg::OP_RED, 6, -6, 0, 0);
      send(rau_pkg::OP_RED, -12, 18, 0, 0);
      send(rau_pkg::OP_RED, 32'h8000_0000, 32'h8000_0000, 0, 0);
      send(rau_pkg::OP_RED, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
      send(rau_pkg::OP_RED, 32'h8000_0000, 32'h4000_0000, 0, 0);
      send(OpSpare6, 1, 1, 1, 1);
      send(OpSpare7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      for (int i = 0; i < NumRequests; i++) begin
         if (i == 300) begin
            req_valid <= 0;
            while (sb.pending_q.size() != 0) @(posedge clock);
         end
         if (i == 480) quiet = 1;
         send_random();
      end
      req_valid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d requests: add %0d sub %0d mul %0d div %0d cmp %0d reduce %0d",
               accepted, sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3],
               sb.op_seen[4], sb.op_seen[5]);
      $display("unused codes %0d, responses checked %0d, mismatches %0d",
               sb.op_seen[6] + sb.op_seen[7], sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("rational_arithmetic_unit regression: pass");
      else
         $display("rational_arithmetic_unit regression: fail");
      $finish;
   end
endmodule
